[hdl/bes_pkg.sv]
// ----------------------------------------------------------------------------
// bes_pkg
// Shared types and constants of the ellipse stepper: request kinds,
// multiplier operand selects and the command and status bundles.
// ----------------------------------------------------------------------------
package bes_pkg;

  localparam int unsigned COLOR_BITS = 24;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic [1:0] LAST_PIXEL = 2'd3;

  typedef enum logic [2:0] {
    MUL_A_SQ = 3'd0,
    MUL_B_SQ = 3'd1,
    MUL_INIT = 3'd2,
    MUL_BX   = 3'd3,
    MUL_AY   = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic       st_aa;
    logic       st_bb;
    logic       init;
    logic       keep_p1;
    logic       decide;
    logic       update;
    logic       push;
    logic [1:0] push_idx;
    logic       push_done;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic step_done;
    logic out_free;
  } status_t;

endpackage

[hdl/bresenham_ellipse_stepper.sv]
// ----------------------------------------------------------------------------
// bresenham_ellipse_stepper
// Axis-aligned ellipse rasterizer walking a Bresenham error term; each step
// but the last emits the four mirrored pixels around the center.
//
// Channel   Direction  Content
// in_*      input      tuser: request kind; tdata: center, semi-axes, color
// out_*     output     tuser: pixel flag, done flag; tlast: last of step;
//                      tdata: pixel column, row, color
//
// Per item: after the accept, a start or an advance runs its compute states
// (AA to SET, or BX to UPD) and then makes 4 transfers (1 done transfer on
// the step that ends the walk); an advance while idle skips the compute
// states and makes 1 done transfer. Products come from the one shared
// multiplier; transfers from the single output register. in_tready is high
// only while idle, and a stalled output holds the sequencer in place. Reset
// clears the sequencer, the walk flag and the output valid.
// ----------------------------------------------------------------------------
module bresenham_ellipse_stepper
  import bes_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned AXIS_BITS  = 11
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [0] req_type
  input  logic in_tuser,
  // center_x, center_y, semi_a, semi_b, color, zero fill
  input  logic [((2*COORD_BITS+2*AXIS_BITS+COLOR_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  output logic out_tlast,
  // [0] pixel_valid, [1] ellipse_done
  output logic [1:0] out_tuser,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [((2*(COORD_BITS+2)+COLOR_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int unsigned CY_LO    = COORD_BITS;
  localparam int unsigned SA_LO    = 2 * COORD_BITS;
  localparam int unsigned SB_LO    = SA_LO + AXIS_BITS;
  localparam int unsigned COL_LO   = SB_LO + AXIS_BITS;
  localparam int unsigned P_BITS   = COORD_BITS + 2;
  localparam int unsigned OUT_BITS = ((2 * P_BITS + COLOR_BITS + 7) / 8) * 8;

  cmd_t    cmd;
  status_t status;

  logic [P_BITS-1:0]     pixel_x, pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  pixel_valid, ellipse_done;

  bes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bes_datapath #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .center_x     (in_tdata[CY_LO-1:0]),
    .center_y     (in_tdata[SA_LO-1:CY_LO]),
    .semi_a       (in_tdata[SB_LO-1:SA_LO]),
    .semi_b       (in_tdata[COL_LO-1:SB_LO]),
    .color        (in_tdata[COL_LO+COLOR_BITS-1:COL_LO]),
    .out_tready   (out_tready),
    .status       (status),
    .out_tvalid   (out_tvalid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .pixel_valid  (pixel_valid),
    .last_of_step (out_tlast),
    .ellipse_done (ellipse_done)
  );

  assign out_tuser = {ellipse_done, pixel_valid};
  assign out_tdata = OUT_BITS'({pixel_color, pixel_y, pixel_x});

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == REQ_START) |=> !in_tready)
    else $error("start request did not occupy the sequencer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push || cmd.push_done) |-> status.out_free)
    else $error("result pushed over a pending transfer");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_done |=> (out_tvalid && out_tlast && out_tuser[1] && !out_tuser[0]))
    else $error("done result malformed");

  a_pixel_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> !out_tuser[1])
    else $error("pixel result flagged as done");

endmodule

[hdl/bes_ctrl.sv]
// ----------------------------------------------------------------------------
// bes_ctrl
// Sequencer of the ellipse stepper: walks the shared multiplier through the
// start and step products, then pushes the mirrored pixels or a done result.
// ----------------------------------------------------------------------------
module bes_ctrl
  import bes_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    req_type,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_AA    = 11'b000_0000_0010,
    ST_BB    = 11'b000_0000_0100,
    ST_INIT  = 11'b000_0000_1000,
    ST_SET   = 11'b000_0001_0000,
    ST_BX    = 11'b000_0010_0000,
    ST_AY    = 11'b000_0100_0000,
    ST_DEC   = 11'b000_1000_0000,
    ST_UPD   = 11'b001_0000_0000,
    ST_EMIT  = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.mul_sel  = MUL_A_SQ;
    cmd.push_idx = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (req_type == REQ_START) begin
            cmd.load  = 1'b1;
            state_nxt = ST_AA;
          end else if (status.running) begin
            state_nxt = ST_BX;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_AA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A_SQ;
        state_nxt   = ST_BB;
      end
      ST_BB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B_SQ;
        cmd.st_aa   = 1'b1;
        state_nxt   = ST_INIT;
      end
      ST_INIT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INIT;
        cmd.st_bb   = 1'b1;
        state_nxt   = ST_SET;
      end
      ST_SET: begin
        cmd.init  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_BX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BX;
        state_nxt   = ST_AY;
      end
      ST_AY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AY;
        cmd.keep_p1 = 1'b1;
        state_nxt   = ST_DEC;
      end
      ST_DEC: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = status.step_done ? ST_DONE : ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.push = 1'b1;
          idx_nxt  = idx_r + 2'd1;
          if (idx_r == LAST_PIXEL) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.push_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        idx_nxt   = 2'd0;
      end
    endcase
  end

endmodule

[hdl/bes_datapath.sv]
// ----------------------------------------------------------------------------
// bes_datapath
// Datapath of the ellipse stepper: shared multiplier, error term, walk
// position, step decision and the registered result stage.
// ----------------------------------------------------------------------------
module bes_datapath
  import bes_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned AXIS_BITS  = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic [COORD_BITS-1:0]   center_x,
  input  logic [COORD_BITS-1:0]   center_y,
  input  logic [AXIS_BITS-1:0]    semi_a,
  input  logic [AXIS_BITS-1:0]    semi_b,
  input  logic [COLOR_BITS-1:0]   color,
  input  logic                    out_tready,
  output status_t                 status,
  output logic                    out_tvalid,
  output logic [COORD_BITS+1:0]   pixel_x,
  output logic [COORD_BITS+1:0]   pixel_y,
  output logic [COLOR_BITS-1:0]   pixel_color,
  output logic                    pixel_valid,
  output logic                    last_of_step,
  output logic                    ellipse_done
);

  localparam int unsigned Y_BITS   = (COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS;
  localparam int unsigned SQ_BITS  = 2 * AXIS_BITS;
  localparam int unsigned MB_BITS  = Y_BITS + 3;
  localparam int unsigned PR_BITS  = SQ_BITS + 1 + MB_BITS;
  localparam int unsigned E_BITS   = SQ_BITS + Y_BITS + 6;
  localparam int unsigned P_BITS   = COORD_BITS + 2;
  localparam int unsigned SUM_BITS = Y_BITS + 2;
  localparam logic [Y_BITS-1:0] Y_KEEP = Y_BITS'((33'd1 << COORD_BITS) - 33'd1);

  logic [COORD_BITS-1:0]      origin_x_r, origin_y_r;
  logic [COLOR_BITS-1:0]      color_r;
  logic [AXIS_BITS-1:0]       a_r, b_r;
  logic [SQ_BITS-1:0]         aa_r, bb_r;
  logic signed [E_BITS-1:0]   aa10_r, bb5_r;
  logic signed [E_BITS-1:0]   err_r, p1_r;
  logic signed [PR_BITS-1:0]  prod_r;
  logic [COORD_BITS-1:0]      cur_x_r;
  logic [Y_BITS-1:0]          cur_y_r;
  logic                       running_r;
  logic                       ta_neg_r, tb_pos_r;

  logic                       out_valid_r;
  logic [P_BITS-1:0]          out_x_r, out_y_r;
  logic [COLOR_BITS-1:0]      out_color_r;
  logic                       out_pvalid_r, out_last_r, out_done_r;

  logic [SQ_BITS-1:0]         mul_a;
  logic signed [MB_BITS-1:0]  mul_b;
  logic signed [PR_BITS-1:0]  mul_full;

  logic signed [E_BITS-1:0]   p2, ta, tb, d_nxt;
  logic                       d_neg, d_zero, move_x, move_y;
  logic [COORD_BITS-1:0]      x_nxt;
  logic [Y_BITS-1:0]          y_dec;

  logic [SUM_BITS-1:0]        sx_plus, sx_minus, sy_plus, sy_minus;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_A_SQ: begin
        mul_a = SQ_BITS'(a_r);
        mul_b = MB_BITS'(a_r);
      end
      MUL_B_SQ: begin
        mul_a = SQ_BITS'(b_r);
        mul_b = MB_BITS'(b_r);
      end
      MUL_INIT: begin
        mul_a = aa_r;
        mul_b = MB_BITS'({b_r, 1'b1});
      end
      MUL_BX: begin
        mul_a = bb_r;
        mul_b = MB_BITS'({cur_x_r, 1'b1}) + MB_BITS'(2);
      end
      MUL_AY: begin
        mul_a = aa_r;
        mul_b = MB_BITS'(3) - MB_BITS'({cur_y_r, 1'b0});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = $signed({1'b0, mul_a}) * mul_b;

  assign p2     = E_BITS'(prod_r);
  assign ta     = (err_r <<< 1) + aa10_r - (p2 <<< 1);
  assign tb     = (err_r <<< 1) + bb5_r - p1_r;
  assign d_neg  = err_r[E_BITS-1];
  assign d_zero = (err_r == '0);

  always_comb begin
    priority if (d_zero) begin
      move_x = 1'b1;
      move_y = 1'b1;
    end else if (d_neg) begin
      move_x = 1'b1;
      move_y = !ta_neg_r;
    end else begin
      move_x = !tb_pos_r;
      move_y = 1'b1;
    end
  end

  assign d_nxt = err_r + (move_x ? p1_r : '0) + (move_y ? p2 : '0);
  assign x_nxt = cur_x_r + COORD_BITS'(move_x);
  assign y_dec = (cur_y_r - Y_BITS'(1)) & Y_KEEP;

  assign sx_plus  = SUM_BITS'(origin_x_r) + SUM_BITS'(cur_x_r);
  assign sx_minus = SUM_BITS'(origin_x_r) - SUM_BITS'(cur_x_r);
  assign sy_plus  = SUM_BITS'(origin_y_r) + SUM_BITS'(cur_y_r);
  assign sy_minus = SUM_BITS'(origin_y_r) - SUM_BITS'(cur_y_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      origin_x_r <= center_x;
      origin_y_r <= center_y;
      color_r    <= color;
      a_r        <= semi_a;
      b_r        <= semi_b;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_full;
    end
    if (cmd.st_aa) begin
      aa_r <= prod_r[SQ_BITS-1:0];
    end
    if (cmd.st_bb) begin
      bb_r <= prod_r[SQ_BITS-1:0];
    end
    if (cmd.keep_p1) begin
      p1_r <= E_BITS'(prod_r);
    end
    if (cmd.init) begin
      err_r   <= E_BITS'(bb_r) - E_BITS'(prod_r);
      aa10_r  <= (E_BITS'(aa_r) <<< 3) + (E_BITS'(aa_r) <<< 1);
      bb5_r   <= (E_BITS'(bb_r) <<< 2) + E_BITS'(bb_r);
      cur_x_r <= '0;
      cur_y_r <= Y_BITS'(b_r);
    end
    if (cmd.decide) begin
      ta_neg_r <= ta[E_BITS-1];
      tb_pos_r <= !tb[E_BITS-1] && (tb != '0);
    end
    if (cmd.update) begin
      err_r   <= d_nxt;
      cur_x_r <= x_nxt;
      cur_y_r <= status.step_done ? '0 : (move_y ? y_dec : cur_y_r);
    end
    if (cmd.push) begin
      out_x_r      <= cmd.push_idx[0] ? sx_minus[P_BITS-1:0] : sx_plus[P_BITS-1:0];
      out_y_r      <= cmd.push_idx[1] ? sy_minus[P_BITS-1:0] : sy_plus[P_BITS-1:0];
      out_color_r  <= color_r;
      out_pvalid_r <= 1'b1;
      out_last_r   <= (cmd.push_idx == LAST_PIXEL);
      out_done_r   <= 1'b0;
    end else if (cmd.push_done) begin
      out_x_r      <= '0;
      out_y_r      <= '0;
      out_color_r  <= '0;
      out_pvalid_r <= 1'b0;
      out_last_r   <= 1'b1;
      out_done_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init) begin
        running_r <= 1'b1;
      end else if (cmd.update && status.step_done) begin
        running_r <= 1'b0;
      end
      if (cmd.push || cmd.push_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.running   = running_r;
  assign status.step_done = move_y && (cur_y_r == '0);
  assign status.out_free  = !out_valid_r || out_tready;

  assign out_tvalid   = out_valid_r;
  assign pixel_x      = out_x_r;
  assign pixel_y      = out_y_r;
  assign pixel_color  = out_color_r;
  assign pixel_valid  = out_pvalid_r;
  assign last_of_step = out_last_r;
  assign ellipse_done = out_done_r;

endmodule
